/* rtl/core/irpd_pkg.sv */
// irpd_pkg: shared widths, register indexes, reset values and decode phase codes
// for the pulse-distance infrared decoder; no dependencies
`default_nettype none

package irpd_pkg;

  localparam int unsigned TsW    = 64;
  localparam int unsigned LimW   = 32;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned CntW   = 6;
  localparam int unsigned PhW    = 3;
  localparam int unsigned CfgIdxW = 3;

  // register indexes on the write port
  localparam logic [CfgIdxW-1:0] CfgStartMarkMin  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStartMarkMax  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStartSpaceMin = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStartSpaceMax = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgEndMarkMax    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgShortLimit    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgLongLimit     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgMaxBits       = 3'd7;

  // register reset values
  localparam logic [LimW-1:0] RstStartMarkMin  = 32'd4000000;
  localparam logic [LimW-1:0] RstStartMarkMax  = 32'd10000000;
  localparam logic [LimW-1:0] RstStartSpaceMin = 32'd4000000;
  localparam logic [LimW-1:0] RstStartSpaceMax = 32'd4900000;
  localparam logic [LimW-1:0] RstEndMarkMax    = 32'd400000;
  localparam logic [LimW-1:0] RstShortLimit    = 32'd827000;
  localparam logic [LimW-1:0] RstLongLimit     = 32'd1800000;
  localparam logic [CntW-1:0] RstMaxBits       = 6'd31;

  localparam logic [CntW-1:0] BitCountMax = 6'd63;

  // decode phases
  localparam logic [PhW-1:0] PhWaitMark  = 3'd0;
  localparam logic [PhW-1:0] PhWaitSpace = 3'd1;
  localparam logic [PhW-1:0] PhBitSpace  = 3'd2;
  localparam logic [PhW-1:0] PhBitMark   = 3'd3;
  localparam logic [PhW-1:0] PhIdle      = 3'd4;

  // opcodes
  localparam logic OpSample = 1'b0;
  localparam logic OpRead   = 1'b1;

endpackage

`default_nettype wire

/* rtl/core/irpd_in_if.sv */
// irpd_in_if: input channel of the infrared decoder, one pin sample or read word
// depends on irpd_pkg
`default_nettype none

interface irpd_in_if;
  import irpd_pkg::*;

  logic           valid;
  logic           ready;
  logic           opcode;
  logic           pin_level;
  logic [TsW-1:0] timestamp_ns;

  modport source (output valid, output opcode, output pin_level, output timestamp_ns,
                  input ready);
  modport sink   (input valid, input opcode, input pin_level, input timestamp_ns,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/irpd_out_if.sv */
// irpd_out_if: result channel of the infrared decoder, read data and frame flag
// depends on irpd_pkg
`default_nettype none

interface irpd_out_if;
  import irpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [CodeW-1:0] read_data;
  logic             frame_done;

  modport source (output valid, output read_data, output frame_done, input ready);
  modport sink   (input valid, input read_data, input frame_done, output ready);
endinterface

`default_nettype wire

/* rtl/core/ir_pulse_distance_decoder.sv */
// ir_pulse_distance_decoder: one input register, decode logic, one result register
// throughput: one word per cycle unless the output stalls; the state update
// (64-bit edge interval subtract and threshold compares) closes in the cycle
// the word leaves the input register
// reset: registers take their default limits, decoder waits for a start mark,
// both channel stages empty
// depends on irpd_pkg, irpd_in_if, irpd_out_if
`default_nettype none

module ir_pulse_distance_decoder (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [irpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [irpd_pkg::LimW-1:0]     cfg_wdata_i,
  irpd_in_if.sink                      in_if,
  irpd_out_if.source                   out_if
);
  import irpd_pkg::*;

  // configuration
  logic [LimW-1:0] start_mark_min_q, start_mark_max_q;
  logic [LimW-1:0] start_space_min_q, start_space_max_q;
  logic [LimW-1:0] end_mark_max_q, short_limit_q, long_limit_q;
  logic [CntW-1:0] max_bits_q;

  // input stage
  logic           in_valid_q;
  logic           in_op_q;
  logic           in_lvl_q;
  logic [TsW-1:0] in_ts_q;

  // decode state
  logic [PhW-1:0]   phase_q, phase_d;
  logic [TsW-1:0]   last_edge_q, last_edge_d;
  logic [CodeW-1:0] shift_q, shift_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             prev_lvl_q, prev_lvl_d;
  logic [CodeW-1:0] code_q, code_d;

  // result stage
  logic             out_valid_q;
  logic [CodeW-1:0] out_data_q, out_data_d;
  logic             out_done_q, out_done_d;

  logic           adv;
  logic [TsW-1:0] dt;
  logic           dt_hi_zero;
  logic           rise, fall;
  logic           gt_smark_min, lt_smark_max, gt_sspace_min, lt_sspace_max;
  logic           lt_end, lt_short, lt_long;

  assign adv         = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || adv;

  assign dt         = in_ts_q - last_edge_q;
  assign dt_hi_zero = (dt[TsW-1:LimW] == '0);
  assign rise       = in_lvl_q && !prev_lvl_q;
  assign fall       = !in_lvl_q && prev_lvl_q;

  // 64-bit interval against 32-bit limits
  assign gt_smark_min  = !dt_hi_zero || (dt[LimW-1:0] > start_mark_min_q);
  assign lt_smark_max  = dt_hi_zero && (dt[LimW-1:0] < start_mark_max_q);
  assign gt_sspace_min = !dt_hi_zero || (dt[LimW-1:0] > start_space_min_q);
  assign lt_sspace_max = dt_hi_zero && (dt[LimW-1:0] < start_space_max_q);
  assign lt_end        = dt_hi_zero && (dt[LimW-1:0] < end_mark_max_q);
  assign lt_short      = dt_hi_zero && (dt[LimW-1:0] < short_limit_q);
  assign lt_long       = dt_hi_zero && (dt[LimW-1:0] < long_limit_q);

  always_comb begin
    phase_d     = phase_q;
    last_edge_d = last_edge_q;
    shift_d     = shift_q;
    count_d     = count_q;
    prev_lvl_d  = prev_lvl_q;
    code_d      = code_q;
    out_data_d  = '0;
    out_done_d  = 1'b0;

    if (in_op_q == OpRead) begin
      out_data_d = code_q;
      code_d     = '0;
    end else begin
      if (rise) begin
        case (phase_q)
          PhWaitMark: begin
            phase_d = (gt_smark_min && lt_smark_max) ? PhWaitSpace : PhIdle;
          end
          PhBitSpace: begin
            if (lt_end || (count_q >= max_bits_q)) begin
              code_d     = shift_q;
              phase_d    = PhIdle;
              out_done_d = 1'b1;
            end else if (lt_short) begin
              phase_d = PhBitMark;
            end
          end
          default: ;
        endcase
        last_edge_d = in_ts_q;
      end else if (fall) begin
        case (phase_q)
          PhIdle: begin
            phase_d = PhWaitMark;
          end
          PhWaitSpace: begin
            phase_d = (gt_sspace_min && lt_sspace_max) ? PhBitSpace : PhIdle;
            shift_d = '0;
            count_d = '0;
          end
          PhBitMark: begin
            if (lt_short || lt_long) begin
              // short space is a zero, medium space a one
              shift_d = {shift_q[CodeW-2:0], !lt_short};
              if (count_q != BitCountMax) count_d = count_q + 1'b1;
            end
            phase_d = PhBitSpace;
          end
          default: ;
        endcase
        last_edge_d = in_ts_q;
      end
      prev_lvl_d = in_lvl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mark_min_q  <= RstStartMarkMin;
      start_mark_max_q  <= RstStartMarkMax;
      start_space_min_q <= RstStartSpaceMin;
      start_space_max_q <= RstStartSpaceMax;
      end_mark_max_q    <= RstEndMarkMax;
      short_limit_q     <= RstShortLimit;
      long_limit_q      <= RstLongLimit;
      max_bits_q        <= RstMaxBits;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartMarkMin:  start_mark_min_q  <= cfg_wdata_i;
        CfgStartMarkMax:  start_mark_max_q  <= cfg_wdata_i;
        CfgStartSpaceMin: start_space_min_q <= cfg_wdata_i;
        CfgStartSpaceMax: start_space_max_q <= cfg_wdata_i;
        CfgEndMarkMax:    end_mark_max_q    <= cfg_wdata_i;
        CfgShortLimit:    short_limit_q     <= cfg_wdata_i;
        CfgLongLimit:     long_limit_q      <= cfg_wdata_i;
        CfgMaxBits:       max_bits_q        <= cfg_wdata_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhWaitMark;
      last_edge_q <= '0;
      shift_q     <= '0;
      count_q     <= '0;
      prev_lvl_q  <= 1'b0;
      code_q      <= '0;
    end else begin
      if (in_if.ready) in_valid_q <= in_if.valid;
      if (adv) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        last_edge_q <= last_edge_d;
        shift_q     <= shift_d;
        count_q     <= count_d;
        prev_lvl_q  <= prev_lvl_d;
        code_q      <= code_d;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_op_q  <= in_if.opcode;
      in_lvl_q <= in_if.pin_level;
      in_ts_q  <= in_if.timestamp_ns;
    end
    if (adv) begin
      out_data_q <= out_data_d;
      out_done_q <= out_done_d;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.read_data  = out_data_q;
  assign out_if.frame_done = out_done_q;

endmodule

`default_nettype wire

/* tb/tb_ir_pulse_distance_decoder.sv */
// tb_ir_pulse_distance_decoder: self-checking bench for the pulse-distance ir decoder,
// timestamped pin words in, read codes and frame flags out, checked against a tracker
// depends on irpd_pkg, irpd_in_if, irpd_out_if and ir_pulse_distance_decoder
`timescale 1ns / 100ps

module tb_ir_pulse_distance_decoder;
  import irpd_pkg::*;

  typedef struct packed {
    logic [CodeW-1:0] read_data;
    logic             frame_done;
  } out_word_t;

  typedef enum logic [1:0] {RxAlways, RxSparse, RxPattern, RxHeavy} rx_mode_e;

  // decoder tracker: own copy of the limits and the decode state
  class irpd_frame_tracker;
    logic [LimW-1:0]  lim [8] = '{RstStartMarkMin, RstStartMarkMax, RstStartSpaceMin,
                                  RstStartSpaceMax, RstEndMarkMax, RstShortLimit,
                                  RstLongLimit, LimW'(RstMaxBits)};
    logic [PhW-1:0]   phase      = PhWaitMark;
    logic [TsW-1:0]   last_edge  = '0;
    logic [CodeW-1:0] shift_word = '0;
    logic [CntW-1:0]  bit_count  = '0;
    logic             prev_level = 1'b0;
    logic [CodeW-1:0] captured   = '0;
    out_word_t        out_words_q [$];
    int unsigned      errors      = 0;
    int unsigned      frames_seen = 0;
    int unsigned      codes_read  = 0;

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [LimW-1:0] val);
      lim[idx] = (idx == CfgMaxBits) ? LimW'(val[CntW-1:0]) : val;
    endfunction

    function void shift_bit(logic b);
      shift_word = {shift_word[CodeW-2:0], b};
      if (bit_count < BitCountMax) bit_count++;
    endfunction

    function void absorb_word(logic op, logic lvl, logic [TsW-1:0] ts);
      out_word_t      r;
      logic [TsW-1:0] gap;
      r = '0;
      if (op == OpRead) begin
        r.read_data = captured;
        captured = '0;
      end else begin
        gap = ts - last_edge;
        if (lvl && !prev_level) begin
          if (phase == PhWaitMark) begin
            phase = (gap > lim[CfgStartMarkMin] && gap < lim[CfgStartMarkMax]) ?
                    PhWaitSpace : PhIdle;
          end else if (phase == PhBitSpace) begin
            if (gap < lim[CfgEndMarkMax] || bit_count >= lim[CfgMaxBits][CntW-1:0]) begin
              captured = shift_word;
              phase = PhIdle;
              r.frame_done = 1'b1;
            end else if (gap < lim[CfgShortLimit]) begin
              phase = PhBitMark;
            end
          end
          last_edge = ts;
        end else if (!lvl && prev_level) begin
          if (phase == PhIdle) begin
            phase = PhWaitMark;
          end else if (phase == PhWaitSpace) begin
            phase = (gap > lim[CfgStartSpaceMin] && gap < lim[CfgStartSpaceMax]) ?
                    PhBitSpace : PhIdle;
            shift_word = '0;
            bit_count = '0;
          end else if (phase == PhBitMark) begin
            if (gap < lim[CfgShortLimit]) shift_bit(1'b0);
            else if (gap < lim[CfgLongLimit]) shift_bit(1'b1);
            phase = PhBitSpace;
          end
          last_edge = ts;
        end
        prev_level = lvl;
      end
      out_words_q.push_back(r);
    endfunction

    function void compare_out_word(logic [CodeW-1:0] data, logic done);
      out_word_t want;
      if (out_words_q.size() == 0) begin
        $error("result word with nothing expected: read_data %0h frame_done %0b", data, done);
        errors++;
        return;
      end
      want = out_words_q.pop_front();
      if (data !== want.read_data) begin
        $error("read_data mismatch: expected %0h, actual %0h", want.read_data, data);
        errors++;
      end
      if (done !== want.frame_done) begin
        $error("frame_done mismatch: expected %0b, actual %0b", want.frame_done, done);
        errors++;
      end
      if (want.frame_done) frames_seen++;
      if (want.read_data != '0) codes_read++;
    endfunction
  endclass

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [LimW-1:0]     cfg_wdata;

  irpd_in_if  in_ch ();
  irpd_out_if out_ch ();

  ir_pulse_distance_decoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  irpd_frame_tracker tracker = new();

  logic [LimW-1:0] cfg_next [8];
  logic [TsW-1:0]  ts_now     = '0;
  logic            line_lvl   = 1'b0;
  int unsigned     burst_left = 0;
  int unsigned     gap_pct    = 0;
  int unsigned     n_sent     = 0;
  int unsigned     n_cfg      = 1;
  rx_mode_e        rx_mode    = RxAlways;
  logic [7:0]      rx_mask    = 8'hff;
  int unsigned     rx_left    = 0;

  always #4 clk = ~clk;

  // receiver: switches between random stall patterns
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(3, 0));
      rx_mask = 8'($urandom) | 8'h01;
      rx_left = 40;
    end
    rx_left--;
    case (rx_mode)
      RxAlways:  out_ch.ready <= 1'b1;
      RxSparse:  out_ch.ready <= ($urandom_range(3, 0) != 0);
      RxPattern: begin
        out_ch.ready <= rx_mask[0];
        rx_mask = {rx_mask[0], rx_mask[7:1]};
      end
      default:   out_ch.ready <= 1'($urandom_range(1, 0));
    endcase
  end

  // values are stable from the falling edge up to the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.compare_out_word(out_ch.read_data, out_ch.frame_done);
  end

  task automatic send_word(input logic op, input logic lvl, input logic [TsW-1:0] ts);
    int unsigned gap;
    logic        hs;
    if (burst_left == 0) begin
      gap = ($urandom_range(99, 0) < gap_pct) ? $urandom_range(8, 1) : 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.pin_level    <= lvl;
    in_ch.timestamp_ns <= ts;
    do begin
      @(negedge clk);
      hs = in_ch.ready;
      @(posedge clk);
    end while (!hs);
    tracker.absorb_word(op, lvl, ts);
    n_sent++;
  endtask

  task automatic pin_edge(input logic lvl, input logic [TsW-1:0] dur);
    ts_now += dur;
    line_lvl = lvl;
    send_word(OpSample, lvl, ts_now);
  endtask

  task automatic send_read();
    send_word(OpRead, 1'($urandom), {$urandom, $urandom});
  endtask

  // sender holds off until every result word is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.out_words_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config();
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CfgIdxW'(i);
      cfg_wdata <= cfg_next[i];
      @(posedge clk);
      tracker.write_reg(CfgIdxW'(i), cfg_next[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_cfg++;
    case ($urandom_range(2, 0))
      0:       gap_pct = 0;
      1:       gap_pct = 25;
      default: gap_pct = 60;
    endcase
  endtask

  function automatic void fill_config(input logic [LimW-1:0] v);
    foreach (cfg_next[i]) cfg_next[i] = v;
  endfunction

  // ordered windows: end mark < short < long, all scaled together
  function automatic void fill_random_config(input int unsigned mb);
    int unsigned scale;
    case ($urandom_range(2, 0))
      0:       scale = 1;
      1:       scale = 1000;
      default: scale = 250000;
    endcase
    cfg_next[CfgStartMarkMin]  = scale * $urandom_range(6000, 0);
    cfg_next[CfgStartMarkMax]  = cfg_next[CfgStartMarkMin] + scale * $urandom_range(9000, 2);
    cfg_next[CfgStartSpaceMin] = scale * $urandom_range(6000, 0);
    cfg_next[CfgStartSpaceMax] = cfg_next[CfgStartSpaceMin] + scale * $urandom_range(9000, 2);
    cfg_next[CfgEndMarkMax]    = scale * $urandom_range(3000, 0);
    cfg_next[CfgShortLimit]    = cfg_next[CfgEndMarkMax] + scale * $urandom_range(4000, 2);
    cfg_next[CfgLongLimit]     = cfg_next[CfgShortLimit] + scale * $urandom_range(6000, 2);
    cfg_next[CfgMaxBits]       = ($urandom & ~32'h3f) | LimW'(mb);
  endfunction

  // inclusive range, with an odd hit right on or just past a boundary
  function automatic logic [TsW-1:0] pick_dur(input longint lo, input longint hi);
    longint v;
    if (hi < lo) begin
      v = lo + longint'($urandom_range(5000, 0));
    end else if ($urandom_range(99, 0) == 0) begin
      case ($urandom_range(3, 0))
        0:       v = lo - 1;
        1:       v = lo;
        2:       v = hi;
        default: v = hi + 1;
      endcase
    end else begin
      v = lo + longint'($urandom_range(32'(hi - lo), 0));
    end
    if (v < 0) v = 0;
    return TsW'(v);
  endfunction

  task automatic send_frame(input bit messy);
    int unsigned mb;
    int unsigned nbits;
    longint      em;
    longint      sl;
    longint      ll;
    logic        b;
    mb = tracker.lim[CfgMaxBits];
    em = longint'(tracker.lim[CfgEndMarkMax]);
    sl = longint'(tracker.lim[CfgShortLimit]);
    ll = longint'(tracker.lim[CfgLongLimit]);
    case ($urandom_range(9, 0))
      0:       ts_now = {$urandom, $urandom};
      1:       ts_now = '1 - TsW'($urandom_range(20_000_000, 0));
      default: ;
    endcase
    if (!line_lvl) pin_edge(1'b1, pick_dur(1, 3_000_000));
    pin_edge(1'b0, pick_dur(1, 20_000_000));
    pin_edge(1'b1, pick_dur(longint'(tracker.lim[CfgStartMarkMin]) + 1,
                            longint'(tracker.lim[CfgStartMarkMax]) - 1));
    pin_edge(1'b0, pick_dur(longint'(tracker.lim[CfgStartSpaceMin]) + 1,
                            longint'(tracker.lim[CfgStartSpaceMax]) - 1));
    nbits = ($urandom_range(3, 0) == 0) ? $urandom_range(mb, 0) : mb;
    for (int i = 0; i < nbits; i++) begin
      if (messy && $urandom_range(11, 0) == 0) begin
        case ($urandom_range(3, 0))
          0: send_word(OpSample, line_lvl, {$urandom, $urandom});
          1: send_read();
          2: begin
            // long mark keeps the decoder waiting for the next mark
            pin_edge(1'b1, pick_dur(sl, sl + 5000));
            pin_edge(1'b0, pick_dur(0, 2000));
          end
          default: begin
            // space too long shifts nothing
            pin_edge(1'b1, pick_dur(em, sl - 1));
            pin_edge(1'b0, pick_dur(ll, ll + 100000));
          end
        endcase
      end
      pin_edge(1'b1, pick_dur(em, sl - 1));
      b = 1'($urandom_range(1, 0));
      pin_edge(1'b0, b ? pick_dur(sl, ll - 1) : pick_dur(0, sl - 1));
    end
    // short end mark, or any mark once the bit count is reached
    pin_edge(1'b1, (nbits >= mb || em == 0) ? pick_dur(em, sl - 1) : pick_dur(0, em - 1));
    if ($urandom_range(1, 0)) send_read();
  endtask

  task automatic run_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned r;
    stop_at = n_sent + budget;
    while (n_sent < stop_at) begin
      r = $urandom_range(99, 0);
      if (r < 55) begin
        send_frame(1'b0);
      end else if (r < 80) begin
        send_frame(1'b1);
      end else if (r < 90) begin
        send_read();
      end else if (r < 99) begin
        repeat ($urandom_range(6, 1)) begin
          case ($urandom_range(3, 0))
            0:       ts_now = {$urandom, $urandom};
            1:       ts_now -= TsW'($urandom_range(1_000_000, 0));
            default: ts_now += TsW'($urandom_range(12_000_000, 0));
          endcase
          line_lvl = 1'($urandom_range(1, 0));
          send_word(OpSample, line_lvl, ts_now);
        end
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    cfg_we             <= 1'b0;
    cfg_idx            <= '0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OpSample;
    in_ch.pin_level    <= 1'b0;
    in_ch.timestamp_ns <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: a start mark straight after reset, then bits of every kind
    pin_edge(1'b1, 64'd5_000_000);
    pin_edge(1'b0, 64'd4_500_000);
    pin_edge(1'b1, 64'd560_000);
    pin_edge(1'b0, 64'd560_000);
    pin_edge(1'b1, 64'd560_000);
    pin_edge(1'b0, 64'd1_690_000);
    send_word(OpSample, 1'b0, ts_now + 64'd7);
    pin_edge(1'b1, 64'd900_000);
    pin_edge(1'b0, 64'd1_000);
    pin_edge(1'b1, 64'd560_000);
    pin_edge(1'b0, 64'd1_900_000);
    send_read();
    pin_edge(1'b1, 64'd560_000);
    pin_edge(1'b0, 64'd826_999);
    pin_edge(1'b1, 64'd560_000);
    pin_edge(1'b0, 64'd827_000);
    pin_edge(1'b1, 64'd399_999);
    send_read();
    send_read();
    // time going backward and wrapping through all ones
    pin_edge(1'b0, -64'd12345);
    ts_now = '1;
    line_lvl = 1'b1;
    send_word(OpSample, 1'b1, ts_now);
    ts_now = '0;
    line_lvl = 1'b0;
    send_word(OpSample, 1'b0, ts_now);
    pin_edge(1'b1, 64'd4_000_001);
    pin_edge(1'b0, 64'd4_000_000);
    send_read();
    run_traffic(300);

    // wide open windows, frames end only on the bit count
    cfg_next[CfgStartMarkMin]  = '0;
    cfg_next[CfgStartMarkMax]  = '1;
    cfg_next[CfgStartSpaceMin] = '0;
    cfg_next[CfgStartSpaceMax] = '1;
    cfg_next[CfgEndMarkMax]    = '0;
    cfg_next[CfgShortLimit]    = '1;
    cfg_next[CfgLongLimit]     = '1;
    cfg_next[CfgMaxBits]       = 32'd32;
    load_config();
    run_traffic(150);

    fill_config('0);
    load_config();
    run_traffic(60);

    fill_random_config(1);
    load_config();
    run_traffic(120);

    fill_random_config(0);
    load_config();
    run_traffic(80);

    fill_random_config(63);
    load_config();
    run_traffic(200);

    fill_config('1);
    load_config();
    run_traffic(40);

    for (int k = 0; k < 5; k++) begin
      fill_random_config(($urandom_range(3, 0) == 0) ? $urandom_range(32, 13) :
                                                       $urandom_range(12, 1));
      load_config();
      run_traffic(150);
    end

    cfg_next[CfgStartMarkMin]  = RstStartMarkMin;
    cfg_next[CfgStartMarkMax]  = RstStartMarkMax;
    cfg_next[CfgStartSpaceMin] = RstStartSpaceMin;
    cfg_next[CfgStartSpaceMax] = RstStartSpaceMax;
    cfg_next[CfgEndMarkMax]    = RstEndMarkMax;
    cfg_next[CfgShortLimit]    = RstShortLimit;
    cfg_next[CfgLongLimit]     = RstLongLimit;
    cfg_next[CfgMaxBits]       = LimW'(RstMaxBits);
    load_config();
    run_traffic(150);

    drain();
    repeat (8) @(posedge clk);
    $display("run covered %0d words under %0d register settings", n_sent, n_cfg);
    $display("%0d frames decoded, %0d nonzero codes read back",
             tracker.frames_seen, tracker.codes_read);
    if (tracker.errors == 0) begin
      $display("** ir_pulse_distance_decoder: PASSED **");
    end else begin
      $display("** ir_pulse_distance_decoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout waiting for result words");
    $display("** ir_pulse_distance_decoder: FAILED **");
    $finish;
  end

endmodule
